// ===== sv/scaled_matrix_multiply_top_defines.svh =====
// Assertion macros for the checker file of the matrix multiplier.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef SCALED_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define SCALED_MATRIX_MULTIPLY_TOP_DEFINES_SVH

`define SMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaled_matrix_multiply assertion failed");

`define SMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaled_matrix_multiply assertion failed");

`endif

// ===== sv/smm_pkg.sv =====
`timescale 1ns / 1ps

package smm_pkg;

    localparam int SMM_MAX_DIM   = 8;
    localparam int SMM_ELEM_BITS = 16;

    localparam int IN_W       = 16;
    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int LD_IDX_W   = 6;
    localparam int ALPHA_W    = 16;
    localparam int ACC_W      = 48;
    localparam int SCALED_W   = ACC_W + ALPHA_W;
    localparam int OUT_W      = 32;
    localparam int FRAC_SHIFT = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 2;
    localparam int TMODE_W    = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [TMODE_W-1:0] TM_NONE = 2'd0;
    localparam logic [TMODE_W-1:0] TM_A    = 2'd1;
    localparam logic [TMODE_W-1:0] TM_B    = 2'd2;
    localparam logic [TMODE_W-1:0] TM_BOTH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_M    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_N    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_P   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 3'd4;

    localparam logic [DIM_W-1:0]          RESET_DIM   = 4'd8;
    localparam logic signed [ALPHA_W-1:0] RESET_ALPHA = 16'sd4096;

    typedef struct packed {
        logic [DIM_W-1:0]          dim_m;
        logic [DIM_W-1:0]          dim_n;
        logic [DIM_W-1:0]          dim_p;
        logic signed [ALPHA_W-1:0] alpha;
        logic [TMODE_W-1:0]        tmode;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] inner;
        logic             first;
        logic             last_k;
        logic             last_elem;
    } step_t;

    typedef struct packed {
        logic                   ld_a;
        logic                   ld_b;
        logic [LD_IDX_W-1:0]    ld_index;
        logic signed [IN_W-1:0] ld_value;
        step_t                  step;
    } cmd_t;

    typedef struct packed {
        logic empty;
    } dp_status_t;

endpackage

// ===== sv/smm_cfg.sv =====
`timescale 1ns / 1ps

module smm_cfg
    import smm_pkg::*;
#(
    parameter int MAX_DIM = SMM_MAX_DIM
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]          rows_m_reg;
    logic [DIM_W-1:0]          cols_n_reg;
    logic [DIM_W-1:0]          inner_p_reg;
    logic signed [ALPHA_W-1:0] scale_alpha_reg;
    logic [TMODE_W-1:0]        transpose_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg         <= RESET_DIM;
            cols_n_reg         <= RESET_DIM;
            inner_p_reg        <= RESET_DIM;
            scale_alpha_reg    <= RESET_ALPHA;
            transpose_mode_reg <= TM_NONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_M:    rows_m_reg         <= cfg_data[DIM_W-1:0];
                REG_COLS_N:    cols_n_reg         <= cfg_data[DIM_W-1:0];
                REG_INNER_P:   inner_p_reg        <= cfg_data[DIM_W-1:0];
                REG_ALPHA:     scale_alpha_reg    <= $signed(cfg_data[ALPHA_W-1:0]);
                REG_TRANSPOSE: transpose_mode_reg <= cfg_data[TMODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

    always_comb
    begin
        cfg.dim_m = clamp_dim(rows_m_reg);
        cfg.dim_n = clamp_dim(cols_n_reg);
        cfg.dim_p = clamp_dim(inner_p_reg);
        cfg.alpha = scale_alpha_reg;
        cfg.tmode = transpose_mode_reg;
    end

endmodule

// ===== sv/smm_ctrl.sv =====
`timescale 1ns / 1ps

module smm_ctrl
    import smm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [MODE_W-1:0]      mode,
    input  logic [LD_IDX_W-1:0]    elem_index,
    input  logic signed [IN_W-1:0] elem_value,
    input  cfg_t                   cfg,
    input  dp_status_t             status,
    output logic                   busy,
    output cmd_t                   cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } ctrl_state_t;

    ctrl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] inner_reg, inner_next;

    logic accept;
    logic last_i;
    logic last_j;
    logic last_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            inner_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            inner_reg <= inner_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign last_i = (DIM_W'(row_reg) + DIM_W'(1)) == cfg.dim_m;
    assign last_j = (DIM_W'(col_reg) + DIM_W'(1)) == cfg.dim_n;
    assign last_k = (DIM_W'(inner_reg) + DIM_W'(1)) == cfg.dim_p;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        inner_next = inner_reg;

        cmd.ld_a     = accept && (mode == MODE_LOAD_A);
        cmd.ld_b     = accept && (mode == MODE_LOAD_B);
        cmd.ld_index = elem_index;
        cmd.ld_value = elem_value;

        cmd.step.valid     = 1'b0;
        cmd.step.row       = row_reg;
        cmd.step.col       = col_reg;
        cmd.step.inner     = inner_reg;
        cmd.step.first     = (inner_reg == '0);
        cmd.step.last_k    = last_k;
        cmd.step.last_elem = last_i && last_j;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode == MODE_COMPUTE) && (cfg.tmode != TM_BOTH))
                begin
                    state_next = S_RUN;
                    row_next   = '0;
                    col_next   = '0;
                    inner_next = '0;
                end
            end
            S_RUN:
            begin
                cmd.step.valid = 1'b1;
                if (!last_k)
                begin
                    inner_next = inner_reg + IDX_W'(1);
                end
                else
                begin
                    inner_next = '0;
                    if (!last_j)
                    begin
                        col_next = col_reg + IDX_W'(1);
                    end
                    else
                    begin
                        col_next = '0;
                        if (!last_i)
                        begin
                            row_next = row_reg + IDX_W'(1);
                        end
                        else
                        begin
                            row_next   = '0;
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                if (status.empty)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/smm_datapath.sv =====
`timescale 1ns / 1ps

module smm_datapath
    import smm_pkg::*;
#(
    parameter int MAX_DIM   = SMM_MAX_DIM,
    parameter int ELEM_BITS = SMM_ELEM_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  cmd_t                    cmd,
    output dp_status_t              status,
    output logic                    out_valid,
    output logic [IDX_W-1:0]        out_row,
    output logic [IDX_W-1:0]        out_col,
    output logic signed [OUT_W-1:0] out_value,
    output logic                    out_last
);

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);
    localparam int LIN_W   = 2 * DIM_W;
    localparam int PW      = 2 * ELEM_BITS;
    localparam int RED_W   = SCALED_W - FRAC_SHIFT;
    localparam logic signed [SCALED_W-1:0] ROUND_BIAS =
        SCALED_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] b_mem [DEPTH];

    logic signed [ELEM_BITS-1:0] ld_elem;
    logic                        ld_in_range;
    logic [LIN_W-1:0]            a_lin;
    logic [LIN_W-1:0]            b_lin;
    logic [AW-1:0]               a_addr;
    logic [AW-1:0]               b_addr;

    logic signed [ELEM_BITS-1:0] a_rd_reg;
    logic signed [ELEM_BITS-1:0] b_rd_reg;
    step_t                       s1_reg;
    logic signed [PW-1:0]        prod_reg;
    step_t                       s2_reg;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        s3_valid_reg;
    logic [IDX_W-1:0]            s3_row_reg;
    logic [IDX_W-1:0]            s3_col_reg;
    logic                        s3_last_reg;
    logic signed [SCALED_W-1:0]  scaled_reg;
    logic                        s4_valid_reg;
    logic [IDX_W-1:0]            s4_row_reg;
    logic [IDX_W-1:0]            s4_col_reg;
    logic                        s4_last_reg;
    logic signed [SCALED_W-1:0]  rounded;
    logic signed [RED_W-1:0]     reduced;
    logic signed [OUT_W-1:0]     sat_value;
    logic                        out_valid_reg;
    logic [IDX_W-1:0]            out_row_reg;
    logic [IDX_W-1:0]            out_col_reg;
    logic signed [OUT_W-1:0]     out_value_reg;
    logic                        out_last_reg;

    generate
        if (ELEM_BITS > IN_W)
        begin : g_ld_ext
            assign ld_elem = {{(ELEM_BITS - IN_W){cmd.ld_value[IN_W-1]}}, cmd.ld_value};
        end
        else
        begin : g_ld_trunc
            assign ld_elem = cmd.ld_value[ELEM_BITS-1:0];
        end

        if (PW >= ACC_W)
        begin : g_prod_trunc
            assign prod_ext = prod_reg[ACC_W-1:0];
        end
        else
        begin : g_prod_ext
            assign prod_ext = {{(ACC_W - PW){prod_reg[PW-1]}}, prod_reg};
        end
    endgenerate

    assign ld_in_range = ({1'b0, cmd.ld_index} < (LD_IDX_W + 1)'(DEPTH));

    always_comb
    begin
        if (cfg.tmode == TM_A)
        begin
            a_lin = LIN_W'(cmd.step.inner) * LIN_W'(cfg.dim_m) + LIN_W'(cmd.step.row);
        end
        else
        begin
            a_lin = LIN_W'(cmd.step.row) * LIN_W'(cfg.dim_p) + LIN_W'(cmd.step.inner);
        end
        if (cfg.tmode == TM_B)
        begin
            b_lin = LIN_W'(cmd.step.col) * LIN_W'(cfg.dim_p) + LIN_W'(cmd.step.inner);
        end
        else
        begin
            b_lin = LIN_W'(cmd.step.inner) * LIN_W'(cfg.dim_n) + LIN_W'(cmd.step.col);
        end
    end

    assign a_addr = a_lin[AW-1:0];
    assign b_addr = b_lin[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.ld_a && ld_in_range)
        begin
            a_mem[cmd.ld_index[AW-1:0]] <= ld_elem;
        end
        if (cmd.ld_b && ld_in_range)
        begin
            b_mem[cmd.ld_index[AW-1:0]] <= ld_elem;
        end
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= cmd.step;
            s2_reg        <= s1_reg;
            s3_valid_reg  <= s2_reg.valid && s2_reg.last_k;
            if (s2_reg.valid)
            begin
                acc_reg <= s2_reg.first ? prod_ext : (acc_reg + prod_ext);
            end
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= a_rd_reg * b_rd_reg;
        s3_row_reg    <= s2_reg.row;
        s3_col_reg    <= s2_reg.col;
        s3_last_reg   <= s2_reg.last_elem;
        scaled_reg    <= acc_reg * cfg.alpha;
        s4_row_reg    <= s3_row_reg;
        s4_col_reg    <= s3_col_reg;
        s4_last_reg   <= s3_last_reg;
        out_row_reg   <= s4_row_reg;
        out_col_reg   <= s4_col_reg;
        out_value_reg <= sat_value;
        out_last_reg  <= s4_last_reg;
    end

    always_comb
    begin
        rounded = scaled_reg + ROUND_BIAS;
        reduced = rounded[SCALED_W-1:FRAC_SHIFT];
        if ((&reduced[RED_W-1:OUT_W-1]) || !(|reduced[RED_W-1:OUT_W-1]))
        begin
            sat_value = reduced[OUT_W-1:0];
        end
        else if (reduced[RED_W-1])
        begin
            sat_value = SAT_MIN;
        end
        else
        begin
            sat_value = SAT_MAX;
        end
    end

    assign status.empty = !(s1_reg.valid || s2_reg.valid || s3_valid_reg
                            || s4_valid_reg || out_valid_reg);

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/scaled_matrix_multiply_top.sv =====
`timescale 1ns / 1ps

// Channel          Signals                                    Transaction
// input item       start, busy, mode, elem_index, elem_value  start high while busy low
// configuration    cfg_we, cfg_index, cfg_data                cfg_we high
// result item      out_valid, out_row, out_col, out_value,    out_valid high, one cycle
//                  out_last
//
// A load leaves busy low, so loads may follow each other every cycle while idle.
// A compute not in TM_BOTH holds busy high through all M*N*P steps and the pipeline
// drain; one multiply-accumulate unit, fed by one read port on each store, takes one
// product per cycle, so each result sums P products. Reset is asynchronous and active low
// and returns the registers to their documented values; the stores hold nothing defined
// until written. The receiver cannot stall: each result is shown for exactly one cycle.

module scaled_matrix_multiply_top
    import smm_pkg::*;
#(
    parameter int MAX_DIM   = SMM_MAX_DIM,
    parameter int ELEM_BITS = SMM_ELEM_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [MODE_W-1:0]       mode,
    input  logic [LD_IDX_W-1:0]     elem_index,
    input  logic signed [IN_W-1:0]  elem_value,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                    out_valid,
    output logic [IDX_W-1:0]        out_row,
    output logic [IDX_W-1:0]        out_col,
    output logic signed [OUT_W-1:0] out_value,
    output logic                    out_last
);

    cfg_t       cfg;
    cmd_t       cmd;
    dp_status_t status;

    smm_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .elem_index (elem_index),
        .elem_value (elem_value),
        .cfg        (cfg),
        .status     (status),
        .busy       (busy),
        .cmd        (cmd)
    );

    smm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (out_last)
    );

endmodule

// ===== sv/smm_checker.sv =====
`timescale 1ns / 1ps

`include "scaled_matrix_multiply_top_defines.svh"

module smm_checker
    import smm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [MODE_W-1:0]       mode,
    input logic                    out_valid,
    input logic [IDX_W-1:0]        out_row,
    input logic                    out_last
);

    `SMM_ASSERT_NOW(a_no_result_when_idle, !busy, !out_valid)

    `SMM_ASSERT_NEXT(a_nothing_after_last, out_valid && out_last, !out_valid)

    `SMM_ASSERT_NEXT(a_load_stays_idle, start && !busy && (mode == MODE_LOAD_A || mode == MODE_LOAD_B), !busy)

    `SMM_ASSERT_NOW(a_row_order, out_valid && $past(out_valid) && !$past(out_last), (out_row == $past(out_row)) || (out_row == IDX_W'($past(out_row) + IDX_W'(1))))

endmodule

bind scaled_matrix_multiply_top smm_checker u_smm_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import smm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int STORE_DEPTH = SMM_MAX_DIM * SMM_MAX_DIM;
    localparam int RANDOM_COMMANDS = 230;

    typedef struct {
        logic [MODE_W-1:0]      mode;
        logic [LD_IDX_W-1:0]    index;
        logic signed [IN_W-1:0] value;
    } mm_cmd_t;

    typedef struct {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [OUT_W-1:0] value;
        logic                    last;
    } c_elem_t;

    logic                    clk;
    logic                    rst_n      = 1'b0;
    logic                    start      = 1'b0;
    logic                    busy;
    logic [MODE_W-1:0]       mode       = MODE_LOAD_A;
    logic [LD_IDX_W-1:0]     elem_index = '0;
    logic signed [IN_W-1:0]  elem_value = '0;
    logic                    cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index  = REG_ROWS_M;
    logic [CFG_DATA_W-1:0]   cfg_data   = '0;
    logic                    out_valid;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [OUT_W-1:0] out_value;
    logic                    out_last;

    scaled_matrix_multiply_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .elem_index (elem_index),
        .elem_value (elem_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .out_last   (out_last)
    );

    // Mirror of the block's registers and stores.
    logic [DIM_W-1:0]          mir_rows  = RESET_DIM;
    logic [DIM_W-1:0]          mir_cols  = RESET_DIM;
    logic [DIM_W-1:0]          mir_inner = RESET_DIM;
    logic signed [ALPHA_W-1:0] mir_alpha = RESET_ALPHA;
    logic [TMODE_W-1:0]        mir_tmode = TM_NONE;
    logic signed [IN_W-1:0]    a_mirror [STORE_DEPTH];
    logic signed [IN_W-1:0]    b_mirror [STORE_DEPTH];

    mm_cmd_t cmd_queue[$];
    c_elem_t c_pending[$];
    mm_cmd_t next_cmd;

    logic took_item = 1'b0;
    int   gap_pct = 0;
    int   errors = 0;
    int   elems_checked = 0;
    int   cmds_sent = 0;
    int   computes_sent = 0;
    int   reg_writes = 0;
    int   phases = 0;

    // Generator view of the configuration and of which store entries hold data.
    int gen_m = 8;
    int gen_n = 8;
    int gen_p = 8;
    logic [TMODE_W-1:0] gen_tm = TM_NONE;
    bit a_loaded [STORE_DEPTH];
    bit b_loaded [STORE_DEPTH];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > SMM_MAX_DIM)
            return SMM_MAX_DIM;
        return int'(d);
    endfunction

    task automatic predict_product();
        int m;
        int n;
        int p;
        int ai;
        int bi;
        logic [ACC_W-1:0]   acc;
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        logic signed [63:0] scaled;
        logic signed [63:0] rounded;
        c_elem_t            e;
        if (mir_tmode == TM_BOTH)
            return;
        m = clamp_dim(mir_rows);
        n = clamp_dim(mir_cols);
        p = clamp_dim(mir_inner);
        for (int i = 0; i < m; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                acc = '0;
                for (int k = 0; k < p; k++)
                begin
                    ai = (mir_tmode == TM_A) ? k * m + i : i * p + k;
                    bi = (mir_tmode == TM_B) ? j * p + k : k * n + j;
                    prod = 64'(a_mirror[ai]) * 64'(b_mirror[bi]);
                    acc = acc + prod[ACC_W-1:0];
                end
                sum = 64'($signed(acc));
                scaled = sum * 64'(mir_alpha);
                rounded = (scaled + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
                if (rounded > 64'sd2147483647)
                    rounded = 64'sd2147483647;
                if (rounded < -64'sd2147483648)
                    rounded = -64'sd2147483648;
                e.row = IDX_W'(i);
                e.col = IDX_W'(j);
                e.value = rounded[OUT_W-1:0];
                e.last = (i == m - 1) && (j == n - 1);
                c_pending.push_back(e);
            end
        end
    endtask

    task automatic check_element();
        c_elem_t e;
        elems_checked++;
        if (c_pending.size() == 0)
        begin
            $display("%0t: unexpected result row %0d col %0d value %0d", $time,
                     out_row, out_col, out_value);
            errors++;
            return;
        end
        e = c_pending.pop_front();
        if (out_row !== e.row)
        begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
            errors++;
        end
        if (out_col !== e.col)
        begin
            $display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
            errors++;
        end
        if (out_value !== e.value)
        begin
            $display("%0t: out_value at (%0d,%0d) expected %0d actual %0d", $time,
                     e.row, e.col, e.value, out_value);
            errors++;
        end
        if (out_last !== e.last)
        begin
            $display("%0t: out_last at (%0d,%0d) expected %0b actual %0b", $time,
                     e.row, e.col, e.last, out_last);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            took_item = 1'b0;
            mir_rows  = RESET_DIM;
            mir_cols  = RESET_DIM;
            mir_inner = RESET_DIM;
            mir_alpha = RESET_ALPHA;
            mir_tmode = TM_NONE;
        end
        else
        begin
            took_item = start && !busy;
            if (out_valid)
                check_element();
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROWS_M:    mir_rows  = cfg_data[DIM_W-1:0];
                    REG_COLS_N:    mir_cols  = cfg_data[DIM_W-1:0];
                    REG_INNER_P:   mir_inner = cfg_data[DIM_W-1:0];
                    REG_ALPHA:     mir_alpha = cfg_data[ALPHA_W-1:0];
                    REG_TRANSPOSE: mir_tmode = cfg_data[TMODE_W-1:0];
                    default:       ;
                endcase
            end
            if (took_item)
            begin
                case (mode)
                    MODE_LOAD_A:  a_mirror[elem_index] = elem_value;
                    MODE_LOAD_B:  b_mirror[elem_index] = elem_value;
                    MODE_COMPUTE: predict_product();
                    default:      ;
                endcase
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took_item)
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                next_cmd = cmd_queue.pop_front();
                start      <= 1'b1;
                mode       <= next_cmd.mode;
                elem_index <= next_cmd.index;
                elem_value <= next_cmd.value;
            end
            else
                start <= 1'b0;
        end
    end

    function automatic logic [IN_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_dim();
        logic [DIM_W-1:0]  d;
        logic [11:0]       upper;
        int                r;
        r = $urandom_range(0, 19);
        if (r == 0)
            d = 4'd0;
        else if (r == 1)
            d = DIM_W'($urandom_range(9, 15));
        else if (r < 4)
            d = 4'd8;
        else if (r < 14)
            d = DIM_W'($urandom_range(1, 4));
        else
            d = DIM_W'($urandom_range(5, 7));
        upper = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'd0;
        return {upper, d};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_alpha();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'(RESET_ALPHA);
            3:       return 16'h0000;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] n,
                              input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] alpha,
                              input logic [CFG_DATA_W-1:0] tm);
        write_reg(REG_ROWS_M, m);
        write_reg(REG_COLS_N, n);
        write_reg(REG_INNER_P, p);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_TRANSPOSE, tm);
        gen_m = clamp_dim(m[DIM_W-1:0]);
        gen_n = clamp_dim(n[DIM_W-1:0]);
        gen_p = clamp_dim(p[DIM_W-1:0]);
        gen_tm = tm[TMODE_W-1:0];
        phases++;
    endtask

    task automatic push_cmd(input logic [MODE_W-1:0] md, input logic [LD_IDX_W-1:0] idx,
                            input logic [IN_W-1:0] value);
        mm_cmd_t c;
        c.mode = md;
        c.index = idx;
        c.value = value;
        cmd_queue.push_back(c);
        cmds_sent++;
        if (md == MODE_LOAD_A)
            a_loaded[idx] = 1'b1;
        else if (md == MODE_LOAD_B)
            b_loaded[idx] = 1'b1;
    endtask

    // A compute only reads entries that already hold data, so any gaps are filled first.
    task automatic push_compute();
        if (gen_tm != TM_BOTH)
        begin
            for (int a = 0; a < gen_m * gen_p; a++)
                if (!a_loaded[a])
                    push_cmd(MODE_LOAD_A, LD_IDX_W'(a), rand_elem());
            for (int b = 0; b < gen_p * gen_n; b++)
                if (!b_loaded[b])
                    push_cmd(MODE_LOAD_B, LD_IDX_W'(b), rand_elem());
        end
        push_cmd(MODE_COMPUTE, LD_IDX_W'($urandom), IN_W'($urandom));
        computes_sent++;
    endtask

    task automatic push_random_load();
        logic [MODE_W-1:0] md;
        int                span;
        md = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
        span = (md == MODE_LOAD_A) ? gen_m * gen_p : gen_p * gen_n;
        if ($urandom_range(0, 3) == 0)
            span = STORE_DEPTH;
        push_cmd(md, LD_IDX_W'($urandom_range(0, span - 1)), rand_elem());
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() > 0 || start || c_pending.size() > 0 || busy)
            @(posedge clk);
        repeat (gen_m * gen_n * gen_p + 16) @(posedge clk);
    endtask

    initial
    begin
        int random_start;
        int gap_steps [4];
        gap_steps = '{0, 50, 0, 12};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(16'd2, 16'd3, 16'd2, 16'(RESET_ALPHA), 16'(TM_NONE));
        push_cmd(MODE_LOAD_A, 6'd0, 16'h7FFF);
        push_cmd(MODE_LOAD_A, 6'd1, 16'h8000);
        push_cmd(MODE_LOAD_A, 6'd2, 16'hFFFF);
        push_cmd(MODE_LOAD_A, 6'd3, 16'h1000);
        push_cmd(MODE_LOAD_B, 6'd0, 16'h8000);
        push_cmd(MODE_LOAD_B, 6'd1, 16'h7FFF);
        push_cmd(MODE_LOAD_B, 6'd2, 16'h0001);
        push_cmd(MODE_LOAD_B, 6'd3, 16'hFFFF);
        push_cmd(MODE_LOAD_B, 6'd4, 16'h0000);
        push_cmd(MODE_LOAD_B, 6'd5, 16'h5A5A);
        push_cmd(MODE_UNUSED, 6'd63, 16'hFFFF);
        push_compute();
        wait_idle();

        for (int r = REG_TRANSPOSE + 1; r < (1 << CFG_IDX_W); r++)
            write_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom));

        set_config(16'd2, 16'd3, 16'd2, 16'h8000, 16'(TM_A));
        push_compute();
        wait_idle();
        set_config(16'd2, 16'd3, 16'd2, 16'h7FFF, 16'(TM_B));
        push_compute();
        wait_idle();
        set_config(16'd2, 16'd3, 16'd2, 16'(RESET_ALPHA), 16'(TM_BOTH));
        push_compute();
        wait_idle();
        set_config(16'd0, 16'd9, 16'd0, 16'h0800, 16'(TM_NONE));
        push_compute();
        wait_idle();

        random_start = cmds_sent;
        for (int ph = 0; cmds_sent - random_start < RANDOM_COMMANDS; ph++)
        begin
            gap_pct = gap_steps[ph % 4];
            if (ph == 1)
                set_config(16'd8, 16'd8, 16'd8, rand_alpha(), 16'(TM_NONE));
            else if (ph == 2)
                set_config(16'd1, 16'd1, 16'd1, rand_alpha(), 16'(TM_B));
            else
                set_config(rand_dim(), rand_dim(), rand_dim(), rand_alpha(),
                           ($urandom_range(0, 9) == 0) ?
                               {14'($urandom), TM_BOTH} :
                               {14'($urandom), TMODE_W'($urandom_range(0, 2))});
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(2, 10))
                    push_random_load();
                if ($urandom_range(0, 5) == 0)
                    push_cmd(MODE_UNUSED, LD_IDX_W'($urandom), IN_W'($urandom));
                push_compute();
            end
            wait_idle();
        end

        $display("Sent %0d commands including %0d computes across %0d configurations",
                 cmds_sent, computes_sent, phases);
        $display("with %0d register writes; %0d result elements were checked.",
                 reg_writes, elems_checked);
        if (errors == 0 && c_pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results still outstanding.", c_pending.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
